@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL. Clock and active-low reset are passed in.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ src/skbs_pkg.sv @@
package skbs_pkg;

    // Table geometry
    localparam int DEPTH_DEFAULT = 128;
    localparam int KEY_W         = 32;
    localparam int IDX_W         = 7;
    localparam int SIZE_W        = 8;
    localparam int POS_W         = 7;

    // Action codes on the input beat
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

endpackage

@@ src/skbs_ram.sv @@
module skbs_ram #(
    parameter int WIDTH = skbs_pkg::KEY_W,
    parameter int DEPTH = skbs_pkg::DEPTH_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, register the read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/sorted_key_binary_search_core.sv @@
// Sorted-key binary search over a table of signed 32-bit keys held in one
// single-port-write, registered-read RAM of DEPTH entries. A write beat
// (action 0) stores its key at entry_index and gives no result; indexes at
// or beyond DEPTH are dropped. A search beat (action 1) probes the midpoints
// of entries 0 .. min(table_size, DEPTH)-1 and returns one result beat:
// found and the 7-bit matching position (0 when not found). Each probe
// issues the midpoint address in PROBE, the RAM registers the read, and CMP
// compares the key and narrows the range. One beat is worked at a time; a
// finished result waits in the output register while the next beat is
// taken. table_size is written through cfg_wr_en/cfg_wr_data; the user must
// do so only while the core is idle, as the block does not enforce it. Keys
// must be written before they are searched.
module sorted_key_binary_search_core #(
    parameter int DEPTH = skbs_pkg::DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration
    input  logic                              cfg_wr_en,
    input  logic [skbs_pkg::SIZE_W-1:0]       cfg_wr_data,
    // Input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [skbs_pkg::IDX_W-1:0]        s_entry_index,
    input  logic signed [skbs_pkg::KEY_W-1:0] s_key_value,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_found,
    output logic [skbs_pkg::POS_W-1:0]        m_position
);

`include "assert_macros.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (CW > skbs_pkg::SIZE_W) ? CW : skbs_pkg::SIZE_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PROBE  = 4'b0010,
        S_CMP    = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    state_t                           state_reg, state_next;
    logic [skbs_pkg::SIZE_W-1:0]      table_size_reg;
    logic signed [skbs_pkg::KEY_W-1:0] key_reg, key_next;
    logic [CW-1:0]                    low_reg, low_next;
    logic [CW-1:0]                    hi_ex_reg, hi_ex_next;
    logic [AW-1:0]                    mid_reg, mid_next;
    logic                             hit_reg, hit_next;
    logic [skbs_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic                             m_valid_reg, m_valid_next;
    logic                             m_found_reg, m_found_next;
    logic [skbs_pkg::POS_W-1:0]       m_position_reg, m_position_next;

    logic                             in_beat;
    logic                             out_free;
    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    logic [skbs_pkg::KEY_W-1:0]       ram_rdata;
    logic signed [skbs_pkg::KEY_W-1:0] probe_key;
    logic [SW-1:0]                    size_wide;
    logic [CW-1:0]                    size_clamped;
    logic [CW-1:0]                    mid_wide;
    logic [CW-1:0]                    span;
    logic                             range_empty;

    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    // Write port: store on a write beat that lands inside the table
    assign ram_we    = in_beat && (s_action == skbs_pkg::ACT_WRITE)
                       && (32'(s_entry_index) < 32'(DEPTH));
    assign ram_waddr = AW'(s_entry_index);

    skbs_ram #(
        .WIDTH (skbs_pkg::KEY_W),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (s_key_value),
        .rd_addr (AW'(mid_wide)),
        .rd_data (ram_rdata)
    );

    assign probe_key = $signed(ram_rdata);

    // Saturate the searched size at DEPTH
    assign size_wide    = SW'(table_size_reg);
    assign size_clamped = (size_wide > SW'(DEPTH)) ? CW'(DEPTH) : CW'(size_wide);

    // Midpoint of the live range [low, hi_ex)
    assign span        = hi_ex_reg - low_reg;
    assign range_empty = (low_reg >= hi_ex_reg);
    assign mid_wide    = low_reg + ((span - CW'(1)) >> 1);

    // Search sequencer
    always_comb begin
        state_next      = state_reg;
        key_next        = key_reg;
        low_next        = low_reg;
        hi_ex_next      = hi_ex_reg;
        mid_next        = mid_reg;
        hit_next        = hit_reg;
        pos_next        = pos_reg;
        m_valid_next    = m_valid_reg;
        m_found_next    = m_found_reg;
        m_position_next = m_position_reg;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_beat && (s_action == skbs_pkg::ACT_SEARCH)) begin
                    key_next   = s_key_value;
                    low_next   = '0;
                    hi_ex_next = size_clamped;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                if (range_empty) begin
                    hit_next   = 1'b0;
                    pos_next   = '0;
                    state_next = S_RESULT;
                end else begin
                    mid_next   = AW'(mid_wide);
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (probe_key == key_reg) begin
                    hit_next   = 1'b1;
                    pos_next   = skbs_pkg::POS_W'(mid_reg);
                    state_next = S_RESULT;
                end else if (probe_key > key_reg) begin
                    hi_ex_next = CW'(mid_reg);
                    state_next = S_PROBE;
                end else begin
                    low_next   = CW'(mid_reg) + CW'(1);
                    state_next = S_PROBE;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_found_next    = hit_reg;
                    m_position_next = pos_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            table_size_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                table_size_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        low_reg        <= low_next;
        hi_ex_reg      <= hi_ex_next;
        mid_reg        <= mid_next;
        hit_reg        <= hit_next;
        pos_reg        <= pos_next;
        m_found_reg    <= m_found_next;
        m_position_reg <= m_position_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_position = m_position_reg;

    // Table writes only happen while no search is in flight
    `ASSERT_IMPL(a_write_idle, aclk, aresetn, ram_we, state_reg == S_IDLE)
    // Probe address stays inside the live range
    `ASSERT_IMPL(a_mid_in_range, aclk, aresetn, (state_reg == S_PROBE) && !range_empty,
        (mid_wide >= low_reg) && (mid_wide < hi_ex_reg))
    // A miss on a probe strictly shrinks the range
    `ASSERT_NEXT(a_range_shrinks, aclk, aresetn,
        (state_reg == S_CMP) && (probe_key != key_reg),
        (hi_ex_reg - low_reg) < $past(hi_ex_reg - low_reg))
    // A finished search lands in the free output register
    `ASSERT_NEXT(a_result_loads, aclk, aresetn, (state_reg == S_RESULT) && out_free,
        m_valid_reg && (state_reg == S_IDLE))

endmodule
